>>> src/ilmb_pkg.sv
// Shared types and constants of the interrupt latch and mask bank.
package ilmb_pkg;

  localparam int WORD_W = 16;
  localparam int ADDR_W = 9;
  localparam int WORD_IDX_W = ADDR_W - 2;
  localparam int SUB_W = 2;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Byte offsets of the raw window, the status window and the mask words.
  localparam logic [ADDR_W-1:0] RAW_BASE    = 9'h040;
  localparam logic [ADDR_W-1:0] STATUS_BASE = 9'h050;
  localparam logic [ADDR_W-1:0] MASK_BASE   = 9'h070;

  localparam logic [WORD_W-1:0] TICK_BITS = 16'(1 << 1);
  localparam logic [WORD_W-1:0] WORD_ONES = 16'hffff;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_READ_RAW,
    OP_READ_MASK,
    OP_READ_MEM,
    OP_CLEAR_RAW,
    OP_WRITE_MASK,
    OP_WRITE_MEM,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [WORD_IDX_W-1:0]   word;
    logic [SUB_W-1:0]        sub;
    logic [WORD_W-1:0]       data;
  } op_t;

endpackage

>>> src/interrupt_latch_mask_bank.sv
// Top level of the interrupt latch and mask bank.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  func, byte_address, write_data
//   out      out_valid / out_ready read_data, irq_line
//
// Every beat in gives one beat out, in order. An accepted input passes through the
// queue and is then held in the result register until it is taken; the bank
// sustains one item per cycle while out_ready stays high, set by the single read
// port of the register store and the one result register.
// Reset clears the raw words, sets the mask words to all ones and marks every
// store word unwritten, so no clearing pass follows reset.
// A two-entry queue lets the input side keep accepting while a result waits.
module interrupt_latch_mask_bank import ilmb_pkg::*; #(
  parameter int BANK_BYTES   = 512,
  parameter int STATUS_WORDS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [ADDR_W-1:0] byte_address,
  input  logic [WORD_W-1:0] write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] read_data,
  output logic              irq_line
);

  logic push;
  op_t  push_op;
  logic q_full;
  logic q_not_empty;
  logic pop;
  op_t  pop_op;

  ilmb_front #(
    .BANK_BYTES   (BANK_BYTES),
    .STATUS_WORDS (STATUS_WORDS)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .byte_address (byte_address),
    .write_data   (write_data),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  ilmb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .pop_op    (pop_op)
  );

  ilmb_back #(
    .BANK_BYTES   (BANK_BYTES),
    .STATUS_WORDS (STATUS_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_op      (pop_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .irq_line  (irq_line)
  );

endmodule

>>> src/ilmb_front.sv
// Front end: takes bus beats and ticks and classifies them into bank operations.
module ilmb_front import ilmb_pkg::*; #(
  parameter int BANK_BYTES   = 512,
  parameter int STATUS_WORDS = 4
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [ADDR_W-1:0]     byte_address,
  input  logic [WORD_W-1:0]     write_data,
  input  logic                  q_full,
  output logic                  push,
  output op_t                   push_op
);

  localparam logic [WORD_IDX_W-1:0] RAW_LO  = RAW_BASE[ADDR_W-1:2];
  localparam logic [WORD_IDX_W-1:0] RAW_HI  = RAW_LO + WORD_IDX_W'(STATUS_WORDS);
  localparam logic [WORD_IDX_W-1:0] STAT_LO = STATUS_BASE[ADDR_W-1:2];
  localparam logic [WORD_IDX_W-1:0] STAT_HI = STAT_LO + WORD_IDX_W'(STATUS_WORDS);
  localparam logic [WORD_IDX_W-1:0] MASK_LO = MASK_BASE[ADDR_W-1:2];
  localparam logic [WORD_IDX_W-1:0] MASK_HI = MASK_LO + WORD_IDX_W'(STATUS_WORDS);

  logic [WORD_IDX_W-1:0] word;
  logic                  raw_hit;
  logic                  stat_hit;
  logic                  mask_hit;
  logic                  in_bank;

  assign word     = byte_address[ADDR_W-1:2];
  assign raw_hit  = (word >= RAW_LO) && (word < RAW_HI);
  assign stat_hit = (word >= STAT_LO) && (word < STAT_HI);
  assign mask_hit = (word >= MASK_LO) && (word < MASK_HI);
  assign in_bank  = 32'(byte_address) < 32'(BANK_BYTES);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_op.kind = OP_NOP;
    push_op.word = word;
    // All three windows start on a four-word boundary, so the low word bits
    // select the status word directly.
    push_op.sub  = byte_address[3:2];
    push_op.data = write_data;
    unique case (func)
      FUNC_READ: begin
        if (raw_hit || stat_hit) begin
          push_op.kind = OP_READ_RAW;
        end else if (in_bank) begin
          push_op.kind = mask_hit ? OP_READ_MASK : OP_READ_MEM;
        end
      end
      FUNC_WRITE: begin
        if (raw_hit) begin
          push_op.kind = OP_CLEAR_RAW;
        end else if (in_bank) begin
          push_op.kind = mask_hit ? OP_WRITE_MASK : OP_WRITE_MEM;
        end
      end
      FUNC_TICK: begin
        push_op.kind = OP_TICK;
      end
      default: begin
        push_op.kind = OP_NOP;
      end
    endcase
  end

endmodule

>>> src/ilmb_queue.sv
// Two-entry queue of decoded operations between the front and back ends.
module ilmb_queue import ilmb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic not_empty,
  output logic full,
  output op_t  pop_op
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = count != '0;
  assign full      = count == CNT_W'(DEPTH);
  assign pop_op    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_op;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue holds more entries than it has");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue push was lost");

endmodule

>>> src/ilmb_back.sv
// Back end: raw status latches, mask words, register store and result register.
module ilmb_back import ilmb_pkg::*; #(
  parameter int BANK_BYTES   = 512,
  parameter int STATUS_WORDS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  op_t               q_op,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] read_data,
  output logic              irq_line
);

  // Only the first 128 words can be reached through a 9-bit address.
  localparam int MEM_DEPTH = (BANK_BYTES / 4 < (1 << WORD_IDX_W)) ?
                             BANK_BYTES / 4 : (1 << WORD_IDX_W);
  localparam int MEM_AW = $clog2(MEM_DEPTH);

  logic [WORD_W-1:0]    raw       [STATUS_WORDS];
  logic [WORD_W-1:0]    raw_next  [STATUS_WORDS];
  logic [WORD_W-1:0]    mask      [STATUS_WORDS];
  logic [WORD_W-1:0]    mask_next [STATUS_WORDS];
  logic [WORD_W-1:0]    mem       [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_valid;
  logic [MEM_AW-1:0]    mem_idx;
  logic [WORD_W-1:0]    cap_data;
  logic                 pending_next;
  logic                 pending_now;

  logic [WORD_W-1:0]    cap_q;
  logic [WORD_W-1:0]    rd_q;
  logic                 rd_valid_q;
  logic                 sel_mem;
  logic                 irq_q;

  assign pop     = q_valid && (!out_valid || out_ready);
  assign mem_idx = q_op.word[MEM_AW-1:0];

  always_comb begin
    cap_data     = '0;
    pending_next = 1'b0;
    pending_now  = 1'b0;
    for (int i = 0; i < STATUS_WORDS; i++) begin
      raw_next[i]  = raw[i];
      mask_next[i] = mask[i];
      if (q_op.sub == SUB_W'(i)) begin
        if (q_op.kind == OP_READ_RAW) begin
          cap_data = cap_data | raw[i];
        end
        if (q_op.kind == OP_READ_MASK) begin
          cap_data = cap_data | mask[i];
        end
      end
      if (pop) begin
        if (q_op.kind == OP_CLEAR_RAW && q_op.sub == SUB_W'(i)) begin
          raw_next[i] = raw[i] & ~q_op.data;
        end
        if (q_op.kind == OP_WRITE_MASK && q_op.sub == SUB_W'(i)) begin
          mask_next[i] = q_op.data;
        end
        if (q_op.kind == OP_TICK && i == 0) begin
          raw_next[i] = raw[i] | TICK_BITS;
        end
      end
      pending_next = pending_next | (|(raw_next[i] & ~mask_next[i]));
      pending_now  = pending_now | (|(raw[i] & ~mask[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mem_valid <= '0;
      for (int i = 0; i < STATUS_WORDS; i++) begin
        raw[i]  <= '0;
        mask[i] <= WORD_ONES;
      end
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      raw  <= raw_next;
      mask <= mask_next;
      if (pop && q_op.kind == OP_WRITE_MEM) begin
        mem_valid[mem_idx] <= 1'b1;
      end
    end
  end

  // A word never written since reset reads as zero through its valid bit.
  always_ff @(posedge clk) begin
    if (pop && q_op.kind == OP_WRITE_MEM) begin
      mem[mem_idx] <= q_op.data;
    end
    if (pop) begin
      rd_q <= mem[mem_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cap_q      <= cap_data;
      rd_valid_q <= mem_valid[mem_idx];
      sel_mem    <= q_op.kind == OP_READ_MEM;
      irq_q      <= pending_next;
    end
  end

  assign read_data = sel_mem ? (rd_valid_q ? rd_q : '0) : cap_q;
  assign irq_line  = irq_q;

  a_tick_latches: assert property (@(posedge clk) disable iff (rst)
    pop && q_op.kind == OP_TICK |=> raw[0][1])
    else $error("frame tick did not latch the vsync bit");

  a_irq_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> irq_line == pending_now)
    else $error("interrupt level disagrees with raw and mask state");

  a_mem_marked: assert property (@(posedge clk) disable iff (rst)
    pop && q_op.kind == OP_WRITE_MEM |=> mem_valid[$past(mem_idx)])
    else $error("store write left its word unmarked");

endmodule
